// File: rtl/mvba_pkg.sv
// Shared types and constants for the matrix-vector score and argmax block.
package mvba_pkg;

  localparam int REQ_W      = 2;
  localparam int COL_W      = 7;
  localparam int IDX_W      = 8;
  localparam int VAL_W      = 32;
  localparam int ELEM_W     = 16;
  localparam int BIAS_W     = 32;
  localparam int PROD_W     = 32;
  localparam int SCORE_W    = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Request codes on the input stream
  localparam logic [REQ_W-1:0] REQ_WEIGHT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BIAS   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ROW    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE  = 2'd2;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_RUN,
    ENG_DRAIN,
    ENG_HOLD
  } eng_state_t;

  typedef struct packed {
    logic busy;
    logic res_vld;
  } eng_stat_t;

  typedef struct packed {
    logic [COL_W-1:0]          best_column;
    logic signed [SCORE_W-1:0] best_score;
  } result_t;

endpackage

// File: rtl/mvba_if.sv
// Stream interfaces for request words and result words.
interface mvba_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [mvba_pkg::REQ_W-1:0]             req_type;
  logic [mvba_pkg::COL_W-1:0]             column;
  logic [mvba_pkg::IDX_W-1:0]             inner_index;
  logic signed [mvba_pkg::VAL_W-1:0]      value;

  modport source (output valid, req_type, column, inner_index, value, input ready);
  modport sink   (input valid, req_type, column, inner_index, value, output ready);
endinterface

interface mvba_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [mvba_pkg::COL_W-1:0]             best_column;
  logic signed [mvba_pkg::SCORE_W-1:0]    best_score;

  modport source (output valid, best_column, best_score, input ready);
  modport sink   (input valid, best_column, best_score, output ready);
endinterface

// File: rtl/mvba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mvba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/mvba_engine.sv
// Dot-product sequencer, MAC pipeline and running argmax.
module mvba_engine #(
  parameter int MAX_INNER   = 256,
  parameter int MAX_COLUMNS = 128,
  localparam int IW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1,
  localparam int LW  = $clog2(MAX_INNER + 1),
  localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int CNW = $clog2(MAX_COLUMNS + 1),
  localparam int WAW = (MAX_COLUMNS * MAX_INNER > 1) ? $clog2(MAX_COLUMNS * MAX_INNER) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [LW-1:0]                      len_eff,
  input  logic [CNW-1:0]                     cols_eff,
  input  logic                               bias_en,
  output logic [IW-1:0]                      row_raddr,
  input  logic [mvba_pkg::ELEM_W-1:0]        row_rdata,
  output logic [WAW-1:0]                     w_raddr,
  input  logic [mvba_pkg::ELEM_W-1:0]        w_rdata,
  output logic [CW-1:0]                      bias_raddr,
  input  logic [mvba_pkg::BIAS_W-1:0]        bias_rdata,
  input  logic                               res_take,
  output mvba_pkg::eng_stat_t                stat,
  output mvba_pkg::result_t                  res
);

  localparam int SW = mvba_pkg::SCORE_W;

  mvba_pkg::eng_state_t state_r, state_nxt;

  logic [IW-1:0]  k_r;
  logic [CW-1:0]  c_r;
  logic [WAW-1:0] wbase_r;
  logic           issue;
  logic           k_last;
  logic           c_last;

  logic           s1_vld_r, s1_first_r, s1_last_r, s1_fin_r;
  logic [CW-1:0]  s1_col_r;
  logic           s2_vld_r, s2_first_r, s2_last_r, s2_fin_r;
  logic [CW-1:0]  s2_col_r;
  logic signed [mvba_pkg::PROD_W-1:0] p_r;
  logic signed [mvba_pkg::BIAS_W-1:0] bias_r;
  logic           s3_vld_r, s3_fin_r;
  logic [CW-1:0]  s3_col_r;
  logic signed [SW-1:0] acc_r;
  logic signed [SW-1:0] best_r;
  logic [CW-1:0]  best_col_r;

  logic signed [SW-1:0] p_ext;
  logic signed [SW-1:0] bias_ext;

  assign k_last = (LW'(k_r) == len_eff - LW'(1));
  assign c_last = (CNW'(c_r) == cols_eff - CNW'(1));

  assign row_raddr  = k_r;
  assign w_raddr    = wbase_r + WAW'(k_r);
  assign bias_raddr = c_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mvba_pkg::ENG_IDLE:  if (start) state_nxt = mvba_pkg::ENG_RUN;
      mvba_pkg::ENG_RUN:   if (k_last && c_last) state_nxt = mvba_pkg::ENG_DRAIN;
      mvba_pkg::ENG_DRAIN: if (s3_vld_r && s3_fin_r) state_nxt = mvba_pkg::ENG_HOLD;
      mvba_pkg::ENG_HOLD:  if (res_take) state_nxt = mvba_pkg::ENG_IDLE;
      default:             state_nxt = mvba_pkg::ENG_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    issue        = 1'b0;
    stat.busy    = 1'b1;
    stat.res_vld = 1'b0;
    unique case (state_r)
      mvba_pkg::ENG_IDLE:  stat.busy = 1'b0;
      mvba_pkg::ENG_RUN:   issue = 1'b1;
      mvba_pkg::ENG_DRAIN: stat.busy = 1'b1;
      mvba_pkg::ENG_HOLD:  stat.res_vld = 1'b1;
      default:             stat.busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mvba_pkg::ENG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Address walk: inner position fastest, then column
  always_ff @(posedge clk) begin
    if (!rst_n || !issue) begin
      k_r     <= '0;
      c_r     <= '0;
      wbase_r <= '0;
    end else if (k_last) begin
      k_r     <= '0;
      c_r     <= c_r + CW'(1);
      wbase_r <= wbase_r + WAW'(MAX_INNER);
    end else begin
      k_r <= k_r + IW'(1);
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && s2_last_r;
    end
  end

  assign p_ext    = {{(SW - mvba_pkg::PROD_W){p_r[mvba_pkg::PROD_W-1]}}, p_r};
  assign bias_ext = {{(SW - mvba_pkg::BIAS_W){bias_r[mvba_pkg::BIAS_W-1]}}, bias_r};

  always_ff @(posedge clk) begin
    // memory read returns alongside stage 1 tags
    s1_first_r <= (k_r == '0);
    s1_last_r  <= k_last;
    s1_fin_r   <= k_last && c_last;
    s1_col_r   <= c_r;

    // multiply
    p_r        <= signed'(row_rdata) * signed'(w_rdata);
    bias_r     <= bias_en ? signed'(bias_rdata) : '0;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_fin_r   <= s1_fin_r;
    s2_col_r   <= s1_col_r;

    // accumulate; bias seeds the sum of each column
    if (s2_vld_r) begin
      acc_r <= (s2_first_r ? bias_ext : acc_r) + p_ext;
    end
    s3_fin_r <= s2_fin_r;
    s3_col_r <= s2_col_r;

    // keep the first strictly larger score
    if (s3_vld_r && (s3_col_r == '0 || acc_r > best_r)) begin
      best_r     <= acc_r;
      best_col_r <= s3_col_r;
    end
  end

  assign res.best_column = mvba_pkg::COL_W'(best_col_r);
  assign res.best_score  = best_r;

endmodule

// File: rtl/matvec_bias_argmax.sv
// Top level: request decode, configuration registers, stores and result register.
//
//  port     dir   role                          payload
//  in_if    sink  weight/bias/row request word  req_type, column, inner_index, value
//  out_if   src   one result word per row       best_column, best_score
//  cfg_*    in    register write, no read-back  cfg_index, cfg_wdata
//
// Weight, bias and row words do not stall the stream by themselves. A row word that closes the
// row holds in_if.ready low until its result moves into the output register: one
// multiply-accumulate per cycle, bounded by the single read port of
// the weight memory, which supplies one weight per cycle. The result word then
// waits in the output register while new request words flow in; a second row
// result waits until that register is taken. Reset clears control state only;
// the stores hold garbage until written and need no clearing pass.
module matvec_bias_argmax #(
  parameter int MAX_INNER   = 256,
  parameter int MAX_COLUMNS = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mvba_in_if.sink                             in_if,
  mvba_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [mvba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mvba_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int LW  = $clog2(MAX_INNER + 1);
  localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNW = $clog2(MAX_COLUMNS + 1);
  localparam int WD  = MAX_COLUMNS * MAX_INNER;
  localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

  // Clamp a Q8.8 word into 16 bits
  function automatic logic signed [mvba_pkg::ELEM_W-1:0] sat16(
    input logic signed [mvba_pkg::VAL_W-1:0] v
  );
    if (v > 32'sd32767) begin
      return 16'sh7fff;
    end else if (v < -32'sd32768) begin
      return 16'sh8000;
    end
    return v[mvba_pkg::ELEM_W-1:0];
  endfunction

  logic [8:0] inner_length_r;
  logic [7:0] column_count_r;
  logic       bias_enable_r;

  logic [LW-1:0]  len_eff;
  logic [CNW-1:0] cols_eff;

  logic accept;
  logic col_ok, pos_ok;
  logic w_we, b_we, r_we;
  logic start;
  logic [mvba_pkg::ELEM_W-1:0] elem;

  logic [IW-1:0]                 row_raddr;
  logic [mvba_pkg::ELEM_W-1:0]   row_rdata;
  logic [WAW-1:0]                w_waddr, w_raddr;
  logic [mvba_pkg::ELEM_W-1:0]   w_rdata;
  logic [CW-1:0]                 bias_raddr;
  logic [mvba_pkg::BIAS_W-1:0]   bias_rdata;

  mvba_pkg::eng_stat_t stat;
  mvba_pkg::result_t   res;
  logic                res_take;

  logic                out_valid_r, out_valid_nxt;
  mvba_pkg::result_t   out_res_r;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_length_r <= 9'd256;
      column_count_r <= 8'd128;
      bias_enable_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mvba_pkg::CFG_INNER_LENGTH: inner_length_r <= cfg_wdata;
        mvba_pkg::CFG_COLUMN_COUNT: column_count_r <= cfg_wdata[7:0];
        mvba_pkg::CFG_BIAS_ENABLE:  bias_enable_r  <= cfg_wdata[0];
        default:                    bias_enable_r  <= bias_enable_r;
      endcase
    end
  end

  // Effective row length and column count
  always_comb begin
    if (inner_length_r == '0) begin
      len_eff = LW'(1);
    end else if (32'(inner_length_r) > MAX_INNER) begin
      len_eff = LW'(MAX_INNER);
    end else begin
      len_eff = LW'(inner_length_r);
    end
    if (32'(column_count_r) > MAX_COLUMNS) begin
      cols_eff = CNW'(MAX_COLUMNS);
    end else begin
      cols_eff = CNW'(column_count_r);
    end
  end

  // Request decode
  assign in_if.ready = !stat.busy;
  assign accept      = in_if.valid && in_if.ready;
  assign col_ok      = (32'(in_if.column) < MAX_COLUMNS);
  assign pos_ok      = (32'(in_if.inner_index) < MAX_INNER);
  assign elem        = sat16(in_if.value);

  assign w_we  = accept && (in_if.req_type == mvba_pkg::REQ_WEIGHT) && col_ok && pos_ok;
  assign b_we  = accept && (in_if.req_type == mvba_pkg::REQ_BIAS) && col_ok;
  assign r_we  = accept && (in_if.req_type == mvba_pkg::REQ_ROW) && pos_ok;
  // the row closes on its last position, provided at least one column is configured
  assign start = accept && (in_if.req_type == mvba_pkg::REQ_ROW)
               && (32'(in_if.inner_index) == 32'(len_eff) - 1)
               && (cols_eff != '0);

  assign w_waddr = WAW'(32'(in_if.column) * MAX_INNER + 32'(in_if.inner_index));

  mvba_ram #(.WIDTH(mvba_pkg::ELEM_W), .DEPTH(WD)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (elem),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  mvba_ram #(.WIDTH(mvba_pkg::BIAS_W), .DEPTH(MAX_COLUMNS)) u_bias_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (CW'(in_if.column)),
    .wdata (in_if.value),
    .raddr (bias_raddr),
    .rdata (bias_rdata)
  );

  mvba_ram #(.WIDTH(mvba_pkg::ELEM_W), .DEPTH(MAX_INNER)) u_row_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (IW'(in_if.inner_index)),
    .wdata (elem),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  mvba_engine #(.MAX_INNER(MAX_INNER), .MAX_COLUMNS(MAX_COLUMNS)) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .len_eff    (len_eff),
    .cols_eff   (cols_eff),
    .bias_en    (bias_enable_r),
    .row_raddr  (row_raddr),
    .row_rdata  (row_rdata),
    .w_raddr    (w_raddr),
    .w_rdata    (w_rdata),
    .bias_raddr (bias_raddr),
    .bias_rdata (bias_rdata),
    .res_take   (res_take),
    .stat       (stat),
    .res        (res)
  );

  // Result register: load when empty or being drained this cycle
  assign res_take = stat.res_vld && (!out_valid_r || out_if.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.best_column = out_res_r.best_column;
  assign out_if.best_score  = out_res_r.best_score;

endmodule

// File: rtl/mvba_checker.sv
// Port-level checks for the matrix-vector score block, bound to the top level.
module mvba_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [mvba_pkg::REQ_W-1:0]        in_req_type,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mvba_pkg::COL_W-1:0]        out_best_column,
  input logic signed [mvba_pkg::SCORE_W-1:0] out_best_score
);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_column)
                                && $stable(out_best_score))
    else $error("result word changed while stalled");

  // no result word straight out of reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a new result only comes out of a compute phase, which holds off requests
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a compute phase");

  // store writes never start a compute phase
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready
    && (in_req_type == mvba_pkg::REQ_WEIGHT || in_req_type == mvba_pkg::REQ_BIAS)
    |=> in_ready)
    else $error("store write stalled the request stream");

endmodule

bind matvec_bias_argmax mvba_checker u_mvba_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .in_req_type     (in_if.req_type),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_best_column (out_if.best_column),
  .out_best_score  (out_if.best_score)
);

// File: verif/matvec_bias_argmax_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for matvec_bias_argmax: random request words, row scoring and checking.
module matvec_bias_argmax_tb;

  localparam int CLK_PERIOD     = 4;
  localparam int ROW_MAX        = 256;
  localparam int COL_MAX        = 128;
  localparam int SETTLE_CYCLES  = 16;    // margin after the last word before a register write
  localparam int TAIL_CYCLES    = 64;
  localparam int HOLD_CYCLES    = 600;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 5000;  // longest quiet stretch is a hold plus two row scans

  // Request code the block ignores
  localparam logic [mvba_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [mvba_pkg::REQ_W-1:0] kind;
    logic [mvba_pkg::COL_W-1:0] column;
    logic [mvba_pkg::IDX_W-1:0] inner;
    logic [mvba_pkg::VAL_W-1:0] value;
  } req_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [mvba_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mvba_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mvba_in_if  req_if ();
  mvba_out_if res_if ();

  matvec_bias_argmax #(
    .MAX_INNER   (ROW_MAX),
    .MAX_COLUMNS (COL_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (req_if),
    .out_if    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Words waiting to be offered, and winners the scoring predicts
  req_word_t         pending_words[$];
  mvba_pkg::result_t expected_winners[$];

  // Predictor copy of the stores and the registers
  shortint     weight_mem [ROW_MAX * COL_MAX];
  int          bias_mem   [COL_MAX];
  shortint     row_mem    [ROW_MAX];
  logic [8:0]  cfg_len  = 9'd256;
  logic [8:0]  cfg_cols = 9'd128;
  logic [8:0]  cfg_bias = 9'd0;

  // Which entries the stimulus has written so far; scans only touch these
  bit weight_known [ROW_MAX * COL_MAX];
  bit bias_known   [COL_MAX];
  bit row_known    [ROW_MAX];
  int words_queued = 0;

  int mismatch_count = 0;
  int idle_cycles    = 0;
  int src_idle       = 0;
  int snk_idle       = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  logic calm;       // no idling on either side
  logic hold_ask;   // ask the receiver for one long hold-off
  req_word_t         next_word;
  mvba_pkg::result_t oldest;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic shortint clip_q88(input logic signed [31:0] v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return shortint'(v[15:0]);
  endfunction

  // Effective row length: 0 acts as 1, beyond the buffer acts as full
  function automatic int unsigned row_len_of(input logic [8:0] w);
    if (w == 9'd0) return 1;
    if (w > ROW_MAX) return ROW_MAX;
    return w;
  endfunction

  // Effective column count: low 8 bits, clamped to the store width
  function automatic int unsigned col_cnt_of(input logic [8:0] w);
    int unsigned n;
    n = w[7:0];
    if (n > COL_MAX) return COL_MAX;
    return n;
  endfunction

  // Apply one accepted word to the predictor; a closing row word scores each
  // configured column and queues the first column with the largest score.
  task automatic score_request(input logic [mvba_pkg::REQ_W-1:0] kind,
                               input logic [mvba_pkg::COL_W-1:0] col,
                               input logic [mvba_pkg::IDX_W-1:0] pos,
                               input logic signed [31:0] val);
    int unsigned len_eff, cols_eff;
    int c, k;
    longint acc, top;
    int top_col;
    mvba_pkg::result_t win;
    case (kind)
      mvba_pkg::REQ_WEIGHT: weight_mem[int'(col) * ROW_MAX + int'(pos)] = clip_q88(val);
      mvba_pkg::REQ_BIAS:   bias_mem[col] = val;
      mvba_pkg::REQ_ROW: begin
        row_mem[pos] = clip_q88(val);
        len_eff  = row_len_of(cfg_len);
        cols_eff = col_cnt_of(cfg_cols);
        if (pos == len_eff - 1 && cols_eff != 0) begin
          top = 0;
          top_col = 0;
          for (c = 0; c < cols_eff; c++) begin
            acc = 0;
            for (k = 0; k < len_eff; k++)
              acc += longint'(row_mem[k]) * longint'(weight_mem[c * ROW_MAX + k]);
            if (cfg_bias[0])
              acc += longint'(bias_mem[c]);
            // strict compare: ties keep the lower column
            if (c == 0 || acc > top) begin
              top = acc;
              top_col = c;
            end
          end
          win.best_column = top_col[mvba_pkg::COL_W-1:0];
          win.best_score  = top[mvba_pkg::SCORE_W-1:0];
          expected_winners.push_back(win);
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Q8.8 operand: mostly in range, some saturating, some tiny values for ties
  function automatic logic [31:0] rand_elem();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_7fff;
          1: return 32'hffff_8000;
          2: return 32'h7fff_ffff;
          default: return 32'h8000_0000;
        endcase
      end
      2: return 32'($urandom_range(0, 8)) - 32'd4;
      default: return {{16{h[15]}}, h};
    endcase
  endfunction

  function automatic logic [31:0] rand_bias();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 8)) - 32'd4;
      1: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input logic [mvba_pkg::REQ_W-1:0] kind,
                           input logic [mvba_pkg::COL_W-1:0] col,
                           input logic [mvba_pkg::IDX_W-1:0] pos,
                           input logic [31:0] val);
    req_word_t w;
    w.kind   = kind;
    w.column = col;
    w.inner  = pos;
    w.value  = val;
    pending_words.push_back(w);
    case (kind)
      mvba_pkg::REQ_WEIGHT: weight_known[int'(col) * ROW_MAX + int'(pos)] = 1'b1;
      mvba_pkg::REQ_BIAS:   bias_known[col] = 1'b1;
      mvba_pkg::REQ_ROW:    row_known[pos] = 1'b1;
      default: ;
    endcase
    if (kind != REQ_UNUSED)
      words_queued++;
  endtask

  // Fill every entry the next scans read that has never been written.
  task automatic prepare_stores(input int unsigned len, input int unsigned cols,
                                input bit bias_on);
    int c, k;
    for (c = 0; c < cols; c++)
      for (k = 0; k < len; k++)
        if (!weight_known[c * ROW_MAX + k])
          push_word(mvba_pkg::REQ_WEIGHT, c[mvba_pkg::COL_W-1:0], k[mvba_pkg::IDX_W-1:0],
                    rand_elem());
    if (bias_on)
      for (c = 0; c < cols; c++)
        if (!bias_known[c])
          push_word(mvba_pkg::REQ_BIAS, c[mvba_pkg::COL_W-1:0], 8'($urandom), rand_bias());
    // write missing row slots in order so a closing word comes last
    for (k = 0; k < len; k++)
      if (!row_known[k])
        push_word(mvba_pkg::REQ_ROW, 7'($urandom), k[mvba_pkg::IDX_W-1:0], rand_elem());
  endtask

  // Random traffic: mostly complete rows, plus stray writes, stray row words and
  // unused requests. All stores the scans read are already written.
  task automatic push_mix(input int n, input int unsigned len);
    int stop, k, m;
    stop = words_queued + n;
    while (words_queued < stop) begin
      case ($urandom_range(0, 9))
        6: push_word(mvba_pkg::REQ_WEIGHT, 7'($urandom), 8'($urandom), rand_elem());
        7: push_word(mvba_pkg::REQ_BIAS, 7'($urandom), 8'($urandom), rand_bias());
        8: push_word(REQ_UNUSED, 7'($urandom), 8'($urandom), $urandom);
        9: push_word(mvba_pkg::REQ_ROW, 7'($urandom), 8'($urandom), rand_elem());
        default: begin
          if (len <= 16) begin
            for (k = 0; k < len; k++)
              push_word(mvba_pkg::REQ_ROW, 7'($urandom), k[mvba_pkg::IDX_W-1:0], rand_elem());
          end else begin
            // long rows: refresh a few slots, then close the row
            m = $urandom_range(1, 8);
            repeat (m)
              push_word(mvba_pkg::REQ_ROW, 7'($urandom), 8'($urandom_range(0, len - 2)),
                        rand_elem());
            push_word(mvba_pkg::REQ_ROW, 7'($urandom), 8'(len - 1), rand_elem());
          end
        end
      endcase
    end
  endtask

  // Wait until every word is taken and every winner has come back, then let
  // the block settle.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_words.size() != 0 || req_if.valid || expected_winners.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers while the block is idle.
  task automatic write_regs(input logic [8:0] len_w, input logic [8:0] cols_w,
                            input logic [8:0] bias_w);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= mvba_pkg::CFG_INNER_LENGTH;
    cfg_wdata <= len_w;
    cfg_len = len_w;
    @(posedge clk);
    cfg_index <= mvba_pkg::CFG_COLUMN_COUNT;
    cfg_wdata <= cols_w;
    cfg_cols = cols_w;
    @(posedge clk);
    cfg_index <= mvba_pkg::CFG_BIAS_ENABLE;
    cfg_wdata <= bias_w;
    cfg_bias = bias_w;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the oldest pending word, hold it until taken, insert bursts
  // of idle cycles unless calm; predict each word at the edge that accepts it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready)
        score_request(req_if.req_type, req_if.column, req_if.inner_index, req_if.value);
      if (!req_if.valid || req_if.ready) begin
        if (src_idle != 0) begin
          src_idle--;
          req_if.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          req_if.valid       <= 1'b1;
          req_if.req_type    <= next_word.kind;
          req_if.column      <= next_word.column;
          req_if.inner_index <= next_word.inner;
          req_if.value       <= next_word.value;
          if (!calm && $urandom_range(0, 7) == 0)
            src_idle = $urandom_range(1, 13);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted winner against the oldest prediction and
  // drive ready with random stalls unless calm, and one long hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_winners.size() == 0) begin
          flag_mismatch($sformatf("result with none pending: column %0d score %0d",
                                  res_if.best_column, res_if.best_score));
        end else begin
          oldest = expected_winners.pop_front();
          if (res_if.best_column !== oldest.best_column)
            flag_mismatch($sformatf("best_column %0d, predicted %0d",
                                    res_if.best_column, oldest.best_column));
          if (res_if.best_score !== oldest.best_score)
            flag_mismatch($sformatf("best_score %0d, predicted %0d",
                                    res_if.best_score, $signed(oldest.best_score)));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_ask && !hold_done) begin
        // hold long enough for the result register to fill and stall the input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else if (snk_idle != 0) begin
        snk_idle--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0)
          snk_idle = $urandom_range(1, 13);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("** matvec_bias_argmax: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    logic [8:0] len_w, cols_w, bias_w;
    int p;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= mvba_pkg::CFG_INNER_LENGTH;
    cfg_wdata <= '0;
    calm      <= 1'b0;
    hold_ask  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: two-slot rows over three columns with bias
    write_regs(9'd2, 9'd3, 9'd1);
    // columns 0 and 1 get equal saturated weights and equal bias: a tie
    push_word(mvba_pkg::REQ_WEIGHT, 7'd0, 8'd0, 32'h7fff_ffff);
    push_word(mvba_pkg::REQ_WEIGHT, 7'd0, 8'd1, 32'h8000_0000);
    push_word(mvba_pkg::REQ_WEIGHT, 7'd1, 8'd0, 32'h0000_7fff);
    push_word(mvba_pkg::REQ_WEIGHT, 7'd1, 8'd1, 32'hffff_8000);
    push_word(mvba_pkg::REQ_WEIGHT, 7'd2, 8'd0, 32'hffff_ffff);
    push_word(mvba_pkg::REQ_WEIGHT, 7'd2, 8'd1, 32'h0000_0005);
    push_word(mvba_pkg::REQ_WEIGHT, 7'd127, 8'd255, 32'h0001_0000);
    push_word(mvba_pkg::REQ_BIAS, 7'd0, 8'd0, 32'd100);
    push_word(mvba_pkg::REQ_BIAS, 7'd1, 8'd0, 32'd100);
    push_word(mvba_pkg::REQ_BIAS, 7'd2, 8'd0, 32'h8000_0000);
    push_word(mvba_pkg::REQ_BIAS, 7'd127, 8'd255, 32'h7fff_ffff);
    // unused request code: dropped by the block
    push_word(REQ_UNUSED, 7'd127, 8'd255, 32'hffff_ffff);
    push_word(mvba_pkg::REQ_ROW, 7'd127, 8'd0, 32'h7fff_ffff);
    push_word(mvba_pkg::REQ_ROW, 7'd0, 8'd1, 32'd1);
    // close again without refreshing slot 0
    push_word(mvba_pkg::REQ_ROW, 7'd0, 8'd1, 32'hffff_8000);
    // slot past the row end: stored, no scan
    push_word(mvba_pkg::REQ_ROW, 7'd0, 8'd255, 32'h8000_0000);
    // zero row: bias alone decides, columns 0 and 1 tie again
    push_word(mvba_pkg::REQ_ROW, 7'd0, 8'd0, 32'd0);
    push_word(mvba_pkg::REQ_ROW, 7'd0, 8'd1, 32'd0);
    push_mix(60, 2);

    // Length 0 acts as 1; zero columns close rows without a result
    write_regs(9'd0, 9'd0, 9'd0);
    prepare_stores(1, 0, 1'b0);
    push_mix(20, 1);

    // Column count above the store width acts as all columns
    write_regs(9'd1, 9'd255, 9'd1);
    prepare_stores(1, COL_MAX, 1'b1);
    push_mix(40, 1);

    // Full-length rows
    write_regs(9'd256, 9'd1, 9'd0);
    prepare_stores(ROW_MAX, 1, 1'b0);
    push_mix(20, ROW_MAX);

    // Length beyond the buffer acts as full; bias enable sees bit 0 only
    write_regs(9'd511, 9'd1, 9'd2);
    push_mix(30, ROW_MAX);

    // Random small shapes; one phase runs under the long receiver hold-off
    for (p = 0; p < 11; p++) begin
      len_w  = 9'($urandom_range(1, 12));
      cols_w = 9'($urandom_range(1, 16));
      bias_w = 9'($urandom_range(0, 1));
      write_regs(len_w, cols_w, bias_w);
      prepare_stores(row_len_of(len_w), col_cnt_of(cols_w), bias_w[0]);
      if (p == 1)
        hold_ask <= 1'b1;
      push_mix(35, row_len_of(len_w));
    end

    // Last stretch at full rate on both sides
    write_regs(9'd8, 9'd8, 9'd1);
    prepare_stores(8, 8, 1'b1);
    calm <= 1'b1;
    push_mix(80, 8);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_winners.size() == 0)
      $display("** matvec_bias_argmax: PASSED **");
    else
      $display("** matvec_bias_argmax: FAILED **");
    $finish;
  end

endmodule
